// ----- design/lfu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU block cache directory package
// Shared widths, request and register codes, scan token and write command
// types, and the saturating count helper.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Default built depth; the design supports 2 to 256 slots
  localparam int unsigned LFU_MAX_ENTRIES = 256;

  // Range of valid ids
  localparam int unsigned LFU_DISK_COUNT      = 16;
  localparam int unsigned LFU_BLOCKS_PER_DISK = 256;

  // Field widths
  localparam int unsigned LFU_TYPE_W  = 2;
  localparam int unsigned LFU_DISK_W  = 4;
  localparam int unsigned LFU_BLOCK_W = 8;
  localparam int unsigned LFU_SLOT_W  = 8;
  localparam int unsigned LFU_CNT_W   = 32;
  localparam int unsigned LFU_OCC_W   = 9;
  localparam int unsigned LFU_CFG_W   = 9;

  // Request kinds
  typedef enum logic [LFU_TYPE_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_UPDATE = 2'd2
  } lfu_req_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_ENABLED = 1'b0,
    CFG_ENTRIES = 1'b1
  } lfu_cfg_e;

  // Tags of the request under way, broadcast to every cell
  typedef struct packed {
    logic [LFU_DISK_W-1:0]  disk;
    logic [LFU_BLOCK_W-1:0] block;
  } lfu_req_t;

  // Scan token flags and least count seen so far
  typedef struct packed {
    logic                 match_found;
    logic                 free_found;
    logic                 least_found;
    logic [LFU_CNT_W-1:0] least_uses;
  } lfu_scan_t;

  // Slot write command: fill with the request tags, or bump the count
  typedef struct packed {
    logic fill;
    logic bump;
  } lfu_wr_t;

  // Saturating increment of a 32-bit count
  function automatic logic [LFU_CNT_W-1:0] lfu_sat_inc(input logic [LFU_CNT_W-1:0] v);
    return (v == '1) ? v : v + LFU_CNT_W'(1);
  endfunction

endpackage

// ----- design/lfu_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU directory cell
// Holds one slot (valid, tags, access count), folds it into the passing scan
// token and registers the token for the next cell.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::LFU_MAX_ENTRIES,
  parameter int unsigned CELL_IDX    = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]  size_i,
  input  lfu_pkg::lfu_req_t                 req_i,
  input  lfu_pkg::lfu_wr_t                  wr_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    wr_idx_i,
  input  lfu_pkg::lfu_scan_t                scan_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    match_idx_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    free_idx_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    least_idx_i,
  output lfu_pkg::lfu_scan_t                scan_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]    match_idx_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]    free_idx_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]    least_idx_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned SZ_W  = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // Slot contents
  logic                            valid_q;
  logic [lfu_pkg::LFU_DISK_W-1:0]  disk_q;
  logic [lfu_pkg::LFU_BLOCK_W-1:0] block_q;
  logic [lfu_pkg::LFU_CNT_W-1:0]   uses_q;

  // Token stage
  lfu_pkg::lfu_scan_t scan_d, scan_q;
  logic [IDX_W-1:0]   match_idx_d, match_idx_q;
  logic [IDX_W-1:0]   free_idx_d, free_idx_q;
  logic [IDX_W-1:0]   least_idx_d, least_idx_q;

  logic in_range;
  logic tag_hit;
  logic sel;

  assign in_range = SZ_W'(CELL_IDX) < size_i;
  assign tag_hit  = valid_q && (disk_q == req_i.disk) && (block_q == req_i.block);
  assign sel      = (wr_idx_i == MY_IDX);

  // Fold this slot into the token; earlier slots win on ties
  always_comb begin
    scan_d      = scan_i;
    match_idx_d = match_idx_i;
    free_idx_d  = free_idx_i;
    least_idx_d = least_idx_i;
    if (in_range) begin
      if (!scan_i.match_found && tag_hit) begin
        scan_d.match_found = 1'b1;
        match_idx_d        = MY_IDX;
      end
      if (!scan_i.free_found && !valid_q) begin
        scan_d.free_found = 1'b1;
        free_idx_d        = MY_IDX;
      end
      // only valid counts are compared; least is used only when all are valid
      if (valid_q && (!scan_i.least_found || (uses_q < scan_i.least_uses))) begin
        scan_d.least_found = 1'b1;
        scan_d.least_uses  = uses_q;
        least_idx_d        = MY_IDX;
      end
    end
  end

  // Token flags and valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      scan_q <= scan_d;
      if (sel && wr_i.fill) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Token indexes and slot payload
  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    least_idx_q <= least_idx_d;
    if (sel && wr_i.fill) begin
      disk_q  <= req_i.disk;
      block_q <= req_i.block;
      uses_q  <= lfu_pkg::LFU_CNT_W'(1);
    end else if (sel && wr_i.bump) begin
      uses_q <= lfu_pkg::lfu_sat_inc(uses_q);
    end
  end

  assign scan_o      = scan_q;
  assign match_idx_o = match_idx_q;
  assign free_idx_o  = free_idx_q;
  assign least_idx_o = least_idx_q;

endmodule

// ----- design/lfu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU directory controller
// Takes requests, holds them while the token walks the cell row, then picks
// the action, writes the chosen slot, updates the totals and registers the
// result transaction.
// ----------------------------------------------------------------------------
module lfu_ctrl #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::LFU_MAX_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // disk_id, block_id, 4'b0
  input  logic [1:0]                        s_axis_tuser,  // req_type
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [71:0]                       m_axis_tdata,  // slot, hit_total, query_total
  output logic [0:0]                        m_axis_tuser,  // status
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [lfu_pkg::LFU_CFG_W-1:0]     cfg_data_i,
  // cell row
  input  lfu_pkg::lfu_scan_t                scan_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    match_idx_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    free_idx_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    least_idx_i,
  output lfu_pkg::lfu_req_t                 req_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]  size_o,
  output lfu_pkg::lfu_wr_t                  wr_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]    wr_idx_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned SZ_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (SZ_W > lfu_pkg::LFU_CFG_W) ? SZ_W : lfu_pkg::LFU_CFG_W;
  localparam int unsigned EXT_W = IDX_W + lfu_pkg::LFU_SLOT_W;
  localparam int unsigned CW    = lfu_pkg::LFU_CNT_W;
  localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(MAX_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e                           state_q, state_d;
  logic [IDX_W-1:0]                 cnt_q, cnt_d;
  logic                             enabled_q, enabled_d;
  logic [lfu_pkg::LFU_CFG_W-1:0]    entries_q, entries_d;
  logic [lfu_pkg::LFU_TYPE_W-1:0]   type_q, type_d;
  lfu_pkg::lfu_req_t                req_q, req_d;
  logic [lfu_pkg::LFU_OCC_W-1:0]    occ_q, occ_d;
  logic [CW-1:0]                    hit_q, hit_d;
  logic [CW-1:0]                    query_q, query_d;
  logic                             m_valid_q, m_valid_d;
  logic [71:0]                      m_data_q, m_data_d;
  logic                             m_status_q, m_status_d;

  logic                             out_free;
  logic                             req_ok;
  logic                             ok;
  logic [IDX_W-1:0]                 slot_idx;
  logic [EXT_W-1:0]                 slot_ext;
  logic [CMP_W-1:0]                 entries_ext;
  logic [CMP_W-1:0]                 size_clamp;

  // Effective size: entries_in_use clamped to [2, MAX_ENTRIES]
  always_comb begin
    entries_ext = CMP_W'(entries_q);
    if (entries_ext < CMP_W'(2)) begin
      size_clamp = CMP_W'(2);
    end else if (entries_ext > CMP_W'(MAX_ENTRIES)) begin
      size_clamp = CMP_W'(MAX_ENTRIES);
    end else begin
      size_clamp = entries_ext;
    end
  end
  assign size_o = SZ_W'(size_clamp);

  assign out_free = !m_valid_q || m_axis_tready;
  assign req_ok   = enabled_q
                 && ((type_q == lfu_pkg::REQ_LOOKUP) || (type_q == lfu_pkg::REQ_INSERT)
                  || (type_q == lfu_pkg::REQ_UPDATE))
                 && (32'(req_q.disk) < lfu_pkg::LFU_DISK_COUNT)
                 && (32'(req_q.block) < lfu_pkg::LFU_BLOCKS_PER_DISK);

  // Action chosen from the finished scan token
  always_comb begin
    ok       = 1'b0;
    slot_idx = '0;
    wr_o     = '0;
    occ_d    = occ_q;
    hit_d    = hit_q;
    query_d  = query_q;
    if (state_q == ST_DECIDE && out_free && req_ok) begin
      case (type_q)
        lfu_pkg::REQ_LOOKUP: begin
          if (occ_q != '0) begin
            query_d = lfu_pkg::lfu_sat_inc(query_q);
            if (scan_i.match_found) begin
              ok        = 1'b1;
              slot_idx  = match_idx_i;
              wr_o.bump = 1'b1;
              hit_d     = lfu_pkg::lfu_sat_inc(hit_q);
            end
          end
        end
        lfu_pkg::REQ_INSERT: begin
          if (!scan_i.match_found) begin
            ok        = 1'b1;
            wr_o.fill = 1'b1;
            if (scan_i.free_found) begin
              slot_idx = free_idx_i;
              occ_d    = (occ_q == '1) ? occ_q : occ_q + lfu_pkg::LFU_OCC_W'(1);
            end else begin
              slot_idx = least_idx_i;
            end
          end
        end
        lfu_pkg::REQ_UPDATE: begin
          if (scan_i.match_found) begin
            ok        = 1'b1;
            slot_idx  = match_idx_i;
            wr_o.bump = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign wr_idx_o = slot_idx;
  assign slot_ext = EXT_W'(slot_idx);
  assign req_o    = req_q;

  // Sequencing, configuration and result register
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    type_d     = type_q;
    req_d      = req_q;
    enabled_d  = enabled_q;
    entries_d  = entries_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_status_d = m_status_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lfu_pkg::CFG_ENABLED: enabled_d = cfg_data_i[0];
        lfu_pkg::CFG_ENTRIES: entries_d = cfg_data_i;
        default:              enabled_d = enabled_q;
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          type_d     = s_axis_tuser;
          req_d.disk  = s_axis_tdata[3:0];
          req_d.block = s_axis_tdata[11:4];
          cnt_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one cell per cycle; the token leaves the last cell after the full row
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == LAST_CNT) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = !ok;
          m_data_d   = {query_d, hit_d, (ok ? slot_ext[7:0] : 8'd0)};
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      type_q     <= '0;
      req_q      <= '0;
      enabled_q  <= 1'b0;
      entries_q  <= lfu_pkg::LFU_CFG_W'(2);
      occ_q      <= '0;
      hit_q      <= '0;
      query_q    <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_status_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      type_q     <= type_d;
      req_q      <= req_d;
      enabled_q  <= enabled_d;
      entries_q  <= entries_d;
      occ_q      <= occ_d;
      hit_q      <= hit_d;
      query_q    <= query_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      m_status_q <= m_status_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  // Slot writes stay inside the live part of the directory
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.fill || wr_o.bump) |-> (SZ_W'(wr_idx_o) < size_o))
    else $error("slot write beyond effective size");

  // An insert never duplicates a tag already present
  a_fill_no_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.fill |-> !scan_i.match_found)
    else $error("fill issued although tag matched");

  // Every counted hit is also a counted lookup
  a_hit_le_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q <= query_q)
    else $error("hit total exceeds query total");

  // A result only appears out of the decide step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DECIDE))
    else $error("result loaded outside decide step");

endmodule

// ----- design/lfu_block_cache_directory.sv -----
`timescale 1ns / 1ps
// Sequence: a request is taken only while idle; the scan token then walks the cell row
//   one slot per cycle, the decide step registers the result (it waits while the
//   result register is still full), and only then is the next request taken.
// Reset: valid bits, occupancy, hit and query totals cleared at once; slot tags
//   and counts are written on fill, so no clearing pass is run.
// ----------------------------------------------------------------------------
// LFU block cache directory
// Fully associative tag directory with least-frequently-used replacement,
// built as a row of slot cells that a scan token walks through.
// ----------------------------------------------------------------------------
module lfu_block_cache_directory #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::LFU_MAX_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [3:0] disk_id, [11:4] block_id
  input  logic [1:0]                    s_axis_tuser,  // [1:0] req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata,  // [7:0] slot, [39:8] hit_total,
                                                       // [71:40] query_total
  output logic [0:0]                    m_axis_tuser,  // [0] status
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [lfu_pkg::LFU_CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned SZ_W  = $clog2(MAX_ENTRIES + 1);

  // Token chain between cells
  lfu_pkg::lfu_scan_t scan_chain  [MAX_ENTRIES+1];
  logic [IDX_W-1:0]   match_chain [MAX_ENTRIES+1];
  logic [IDX_W-1:0]   free_chain  [MAX_ENTRIES+1];
  logic [IDX_W-1:0]   least_chain [MAX_ENTRIES+1];

  lfu_pkg::lfu_req_t  req;
  lfu_pkg::lfu_wr_t   wr;
  logic [IDX_W-1:0]   wr_idx;
  logic [SZ_W-1:0]    size;

  // Fresh token at the head of the row
  assign scan_chain[0]  = '0;
  assign match_chain[0] = '0;
  assign free_chain[0]  = '0;
  assign least_chain[0] = '0;

  // Row of slot cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .size_i      (size),
      .req_i       (req),
      .wr_i        (wr),
      .wr_idx_i    (wr_idx),
      .scan_i      (scan_chain[g]),
      .match_idx_i (match_chain[g]),
      .free_idx_i  (free_chain[g]),
      .least_idx_i (least_chain[g]),
      .scan_o      (scan_chain[g+1]),
      .match_idx_o (match_chain[g+1]),
      .free_idx_o  (free_chain[g+1]),
      .least_idx_o (least_chain[g+1])
    );
  end

  // Request sequencing and result
  lfu_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .scan_i        (scan_chain[MAX_ENTRIES]),
    .match_idx_i   (match_chain[MAX_ENTRIES]),
    .free_idx_i    (free_chain[MAX_ENTRIES]),
    .least_idx_i   (least_chain[MAX_ENTRIES]),
    .req_o         (req),
    .size_o        (size),
    .wr_o          (wr),
    .wr_idx_o      (wr_idx)
  );

endmodule
